### rtl/ppu_pkg.sv
// shared types and constants for the pixel point operation unit
package ppu_pkg;

    // number of channels in one pixel
    localparam int MAX_CHANNELS = 4;

    // register file geometry
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MODE          = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_BRIGHT_OFFSET = 2'd2;
    localparam logic [1:0] REG_CONTRAST_GAIN = 2'd3;

    // operation codes; the codes above MODE_PASS act as pass-through
    localparam logic [2:0] MODE_INVERT   = 3'd0;
    localparam logic [2:0] MODE_GRAY     = 3'd1;
    localparam logic [2:0] MODE_BRIGHT   = 3'd2;
    localparam logic [2:0] MODE_CONTRAST = 3'd3;
    localparam logic [2:0] MODE_PASS     = 3'd4;

    // reset values of the registers
    localparam logic [2:0]         RST_MODE          = MODE_PASS;
    localparam logic [2:0]         RST_CHANNEL_COUNT = 3'd3;
    localparam logic signed [8:0]  RST_BRIGHT_OFFSET = 9'sd0;
    localparam logic signed [15:0] RST_CONTRAST_GAIN = 16'sd256;

    // luma weights in q16
    localparam logic [15:0] W_RED   = 16'd19595;
    localparam logic [15:0] W_GREEN = 16'd38470;
    localparam logic [15:0] W_BLUE  = 16'd7471;

    // contrast midpoint as an integer, and the midpoint in q8.8 added back after the gain
    localparam logic signed [8:0]  MID_LEVEL     = 9'sd128;
    localparam logic signed [25:0] CONTRAST_BIAS = 26'sd32768;

    // configuration seen by the datapath
    typedef struct packed {
        logic [2:0]         mode;
        logic [2:0]         chan_count;
        logic signed [8:0]  bright_offset;
        logic signed [15:0] contrast_gain;
    } cfg_t;

endpackage

### rtl/pixel_point_operation_unit_core.sv
// top level of the pixel point operation unit: registers, pipeline and grayscale
//
//  channel | signals                                  | transfer when
//  --------+------------------------------------------+--------------------------
//  in      | in_valid, in_stall, in_ch0..in_ch3       | in_valid && !in_stall
//  out     | out_valid, out_stall, out_ch0..out_ch3   | out_valid && !out_stall
//  cfg     | psel, penable, pwrite, paddr, pwdata ... | psel && penable && pwrite
//
// two register stages: input register, then result register; a pixel moves
// from one to the next, one pixel per cycle sustained unless out_stall holds.
// the operation itself is one pass of combinational logic between the stages.
// rst_n clears both valid flags and loads the register reset values.
// out_stall backs up into the input register and then into in_stall.
module pixel_point_operation_unit_core
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   in_ch0,
    input  logic [7:0]                   in_ch1,
    input  logic [7:0]                   in_ch2,
    input  logic [7:0]                   in_ch3,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   out_ch0,
    output logic [7:0]                   out_ch1,
    output logic [7:0]                   out_ch2,
    output logic [7:0]                   out_ch3,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppu_pkg::ADDR_W-1:0]   paddr,
    input  logic [ppu_pkg::DATA_W-1:0]   pwdata,
    output logic [ppu_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    ppu_pkg::cfg_t cfg_reg;
    logic          cfg_wr;

    logic          s1_valid_reg;
    logic [7:0]    s1_pix_reg [ppu_pkg::MAX_CHANNELS];
    logic          out_valid_reg;
    logic [7:0]    out_pix_reg [ppu_pkg::MAX_CHANNELS];

    logic          out_ready;
    logic          s1_adv;
    logic          in_xfer;

    logic [2:0]    cnt_sat;
    logic          gray_en;
    logic [23:0]   luma_sum;
    logic [7:0]    lane_pix [ppu_pkg::MAX_CHANNELS];
    logic [7:0]    res_pix  [ppu_pkg::MAX_CHANNELS];

    // register write and read
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= ppu_pkg::RST_MODE;
            cfg_reg.chan_count    <= ppu_pkg::RST_CHANNEL_COUNT;
            cfg_reg.bright_offset <= ppu_pkg::RST_BRIGHT_OFFSET;
            cfg_reg.contrast_gain <= ppu_pkg::RST_CONTRAST_GAIN;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                ppu_pkg::REG_MODE:          cfg_reg.mode          <= pwdata[2:0];
                ppu_pkg::REG_CHANNEL_COUNT: cfg_reg.chan_count    <= pwdata[2:0];
                ppu_pkg::REG_BRIGHT_OFFSET: cfg_reg.bright_offset <= $signed(pwdata[8:0]);
                ppu_pkg::REG_CONTRAST_GAIN: cfg_reg.contrast_gain <= $signed(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ppu_pkg::REG_MODE:
                prdata = {29'd0, cfg_reg.mode};
            ppu_pkg::REG_CHANNEL_COUNT:
                prdata = {29'd0, cfg_reg.chan_count};
            ppu_pkg::REG_BRIGHT_OFFSET:
                prdata = {{23{cfg_reg.bright_offset[8]}}, cfg_reg.bright_offset};
            ppu_pkg::REG_CONTRAST_GAIN:
                prdata = {{16{cfg_reg.contrast_gain[15]}}, cfg_reg.contrast_gain};
            default:
                prdata = '0;
        endcase
    end

    // pipeline flow control
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_xfer   = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_pix_reg[0] <= in_ch0;
            s1_pix_reg[1] <= in_ch1;
            s1_pix_reg[2] <= in_ch2;
            s1_pix_reg[3] <= in_ch3;
        end
    end

    // effective channel count, saturated at MAX_CHANNELS
    assign cnt_sat = (cfg_reg.chan_count > 3'(ppu_pkg::MAX_CHANNELS))
                   ? 3'(ppu_pkg::MAX_CHANNELS) : cfg_reg.chan_count;
    assign gray_en = (cfg_reg.mode == ppu_pkg::MODE_GRAY) && (cnt_sat >= 3'd3);

    // q16 luma of channels 0..2, constant weights
    assign luma_sum = ({16'd0, s1_pix_reg[0]} * {8'd0, ppu_pkg::W_RED})
                    + ({16'd0, s1_pix_reg[1]} * {8'd0, ppu_pkg::W_GREEN})
                    + ({16'd0, s1_pix_reg[2]} * {8'd0, ppu_pkg::W_BLUE});

    // per-channel lanes and result select
    for (genvar i = 0; i < ppu_pkg::MAX_CHANNELS; i++)
    begin : g_lane
        ppu_lane u_lane
        (
            .cfg     (cfg_reg),
            .en      (3'(i) < cnt_sat),
            .pix_in  (s1_pix_reg[i]),
            .pix_out (lane_pix[i])
        );

        assign res_pix[i] = (gray_en && (i < 3)) ? luma_sum[23:16] : lane_pix[i];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            out_pix_reg <= res_pix;
    end

    assign out_valid = out_valid_reg;
    assign out_ch0   = out_pix_reg[0];
    assign out_ch1   = out_pix_reg[1];
    assign out_ch2   = out_pix_reg[2];
    assign out_ch3   = out_pix_reg[3];

    // a held result with a full input register must stall the input side
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && out_stall |-> in_stall)
        else $error("input not stalled while pipeline is full");

    // a pixel leaving the input register shows up as a result next cycle
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced pixel lost");

    // pass-through leaves channel 3 untouched
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && (cfg_reg.mode == ppu_pkg::MODE_PASS) && !cfg_wr
        |=> out_ch3 == $past(s1_pix_reg[3]))
        else $error("pass-through changed channel 3");

    // grayscale writes one luma value to channels 0..2
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && gray_en |=> (out_ch0 == out_ch1) && (out_ch1 == out_ch2))
        else $error("grayscale channels differ");

endmodule

### rtl/ppu_lane.sv
// per-channel point operation: invert, brightness and contrast
module ppu_lane
(
    input  ppu_pkg::cfg_t cfg,
    input  logic          en,
    input  logic [7:0]    pix_in,
    output logic [7:0]    pix_out
);

    logic signed [9:0]  bright_sum;
    logic signed [8:0]  diff;
    logic signed [24:0] prod;
    logic signed [25:0] con_sum;
    logic [7:0]         bright_pix;
    logic [7:0]         con_pix;

    // brightness: add signed offset, clamp to 0..255
    assign bright_sum = $signed({2'b00, pix_in})
                      + $signed({cfg.bright_offset[8], cfg.bright_offset});

    always_comb
    begin
        if (bright_sum[9])
            bright_pix = 8'd0;
        else if (bright_sum[8])
            bright_pix = 8'd255;
        else
            bright_pix = bright_sum[7:0];
    end

    // contrast: (v - 128) * gain + 128 in q8.8, truncate, clamp
    assign diff    = $signed({1'b0, pix_in}) - ppu_pkg::MID_LEVEL;
    assign prod    = diff * cfg.contrast_gain;
    assign con_sum = $signed({prod[24], prod}) + ppu_pkg::CONTRAST_BIAS;

    always_comb
    begin
        if (con_sum[25])
            con_pix = 8'd0;
        else if (|con_sum[24:16])
            con_pix = 8'd255;
        else
            con_pix = con_sum[15:8];
    end

    // operation select; disabled lanes and unused codes pass through
    always_comb
    begin
        pix_out = pix_in;
        if (en)
        begin
            case (cfg.mode)
                ppu_pkg::MODE_INVERT:   pix_out = 8'd255 - pix_in;
                ppu_pkg::MODE_BRIGHT:   pix_out = bright_pix;
                ppu_pkg::MODE_CONTRAST: pix_out = con_pix;
                default:                pix_out = pix_in;
            endcase
        end
    end

endmodule
